[rtl/core/xfc_pkg.sv]
// Shared types and constants for the XMODEM frame checker.
// No dependencies; imported by every module of the block.
package xfc_pkg;

	localparam int SHORT_PAYLOAD_DEF = 128;
	localparam int LONG_PAYLOAD_DEF  = 1024;

	localparam int BYTE_W   = 8;
	localparam int INDEX_W  = 10;
	localparam int CFG_IDX_W = 1;

	localparam logic [BYTE_W:0] BLOCK_PAIR_SUM = 9'h0ff;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_START = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_START  = 1'b1;

	localparam logic [BYTE_W-1:0] SHORT_START_RST = 8'h01;
	localparam logic [BYTE_W-1:0] LONG_START_RST  = 8'h02;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_START  = 2'd1,
		ST_BAD_COMPL  = 2'd2,
		ST_SUM_ERR    = 2'd3
	} status_t;

	typedef struct packed {
		logic              is_payload;
		logic [BYTE_W-1:0] payload_byte;
		logic [INDEX_W-1:0] payload_index;
		logic              frame_done;
		status_t           status;
		logic [BYTE_W-1:0] sum_difference;
		logic [BYTE_W-1:0] block_number;
		logic              long_frame;
	} res_t;

	typedef struct packed {
		logic [BYTE_W-1:0] short_start;
		logic [BYTE_W-1:0] long_start;
	} cfg_t;

endpackage

[rtl/core/xmodem_frame_checker_core.sv]
// XMODEM frame checker: one received byte per item in, at most one result per item out.
// Start byte selects a short (checksum) or long frame; header complement and short-frame
// checksum are checked, payload bytes are passed out with their index. Each item goes
// through the input register, then the result register; one item is accepted every cycle
// while the output buffer has room; the frame state (position, running sum) is registered.
// Depends on xfc_pkg, xfc_cfg, xfc_step and xfc_out_buf.
module xmodem_frame_checker_core #(
	parameter int SHORT_PAYLOAD = xfc_pkg::SHORT_PAYLOAD_DEF,
	parameter int LONG_PAYLOAD  = xfc_pkg::LONG_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [xfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [xfc_pkg::BYTE_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // rx_byte
	input  logic                          s_tuser,  // frame_first
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// payload_byte, payload_index, status, sum_difference, block_number, long_frame, zero pad
	output logic [39:0]                   m_tdata,
	output logic                          m_tuser,  // is_payload
	output logic                          m_tlast   // frame_done
);
	import xfc_pkg::*;

	cfg_t cfg;
	res_t res, out_res;
	logic res_valid, room;

	xfc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	xfc_step #(
		.SHORT_PAYLOAD (SHORT_PAYLOAD),
		.LONG_PAYLOAD  (LONG_PAYLOAD)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_first  (s_tuser),
		.res_room  (room),
		.res_valid (res_valid),
		.res       (res)
	);

	xfc_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {3'b000, out_res.long_frame, out_res.block_number,
		out_res.sum_difference, out_res.status, out_res.payload_index,
		out_res.payload_byte};
	assign m_tuser = out_res.is_payload;
	assign m_tlast = out_res.frame_done;

endmodule

[rtl/core/xfc_cfg.sv]
// Start-code configuration registers for the XMODEM frame checker.
// Depends on xfc_pkg.
module xfc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [xfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [xfc_pkg::BYTE_W-1:0]    cfg_data,
	output xfc_pkg::cfg_t                 cfg
);
	import xfc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_start <= SHORT_START_RST;
			cfg_q.long_start  <= LONG_START_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SHORT_START: cfg_q.short_start <= cfg_data;
				CFG_LONG_START:  cfg_q.long_start  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/xfc_step.sv]
// Input register and per-byte frame state update for the XMODEM frame checker.
// Depends on xfc_pkg; results go to xfc_out_buf.
module xfc_step #(
	parameter int SHORT_PAYLOAD = xfc_pkg::SHORT_PAYLOAD_DEF,
	parameter int LONG_PAYLOAD  = xfc_pkg::LONG_PAYLOAD_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  xfc_pkg::cfg_t              cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [xfc_pkg::BYTE_W-1:0] in_byte,
	input  logic                       in_first,
	input  logic                       res_room,
	output logic                       res_valid,
	output xfc_pkg::res_t              res
);
	import xfc_pkg::*;

	localparam int POS_MAX = ((LONG_PAYLOAD > SHORT_PAYLOAD) ? LONG_PAYLOAD : SHORT_PAYLOAD) + 3;
	localparam int POS_W   = $clog2(POS_MAX + 1);
	localparam int IDX_W   = (POS_W > INDEX_W) ? POS_W : INDEX_W;
	localparam logic [POS_W-1:0] SHORT_END = POS_W'(SHORT_PAYLOAD + 3);
	localparam logic [POS_W-1:0] LONG_END  = POS_W'(LONG_PAYLOAD + 3);
	localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_TWO   = POS_W'(2);
	localparam logic [POS_W-1:0] POS_THREE = POS_W'(3);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              first_s1;
	logic              adv_s1;

	logic [POS_W-1:0]  pos_q, pos_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic              long_q, long_d;
	logic              skip_q, skip_d;
	logic [BYTE_W-1:0] blk_q, blk_d;

	logic [POS_W-1:0]  end_pos;
	logic [IDX_W-1:0]  idx_ext;
	logic [BYTE_W-1:0] diff;
	logic              hit;

	assign adv_s1   = valid_s1 && res_room;
	assign in_ready = !valid_s1 || res_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			first_s1 <= in_first;
		end
	end

	assign end_pos = long_q ? LONG_END : SHORT_END;
	assign idx_ext = IDX_W'(pos_q - POS_THREE);
	assign diff    = sum_q - byte_s1;

	always_comb begin
		pos_d  = pos_q;
		sum_d  = sum_q;
		long_d = long_q;
		skip_d = skip_q;
		blk_d  = blk_q;
		hit    = 1'b0;
		res    = '0;
		if (first_s1) begin
			sum_d = '0;
			blk_d = '0;
			if (byte_s1 == cfg.short_start || byte_s1 == cfg.long_start) begin
				long_d = (byte_s1 != cfg.short_start);
				pos_d  = POS_ONE;
				skip_d = 1'b0;
			end else begin
				long_d            = 1'b0;
				pos_d             = '0;
				skip_d            = 1'b1;
				hit               = 1'b1;
				res.frame_done    = 1'b1;
				res.status        = ST_BAD_START;
			end
		end else if (!skip_q) begin
			priority if (pos_q == POS_ONE) begin
				blk_d = byte_s1;
				pos_d = POS_TWO;
			end else if (pos_q == POS_TWO) begin
				if ({1'b0, blk_q} + {1'b0, byte_s1} != BLOCK_PAIR_SUM) begin
					skip_d           = 1'b1;
					hit              = 1'b1;
					res.frame_done   = 1'b1;
					res.status       = ST_BAD_COMPL;
					res.block_number = blk_q;
					res.long_frame   = long_q;
				end else begin
					pos_d = POS_THREE;
				end
			end else if (pos_q < end_pos) begin
				sum_d             = sum_q + byte_s1;
				pos_d             = pos_q + POS_ONE;
				hit               = 1'b1;
				res.is_payload    = 1'b1;
				res.payload_byte  = byte_s1;
				res.payload_index = idx_ext[INDEX_W-1:0];
				res.block_number  = blk_q;
				res.long_frame    = long_q;
			end else if (!long_q) begin
				skip_d             = 1'b1;
				hit                = 1'b1;
				res.frame_done     = 1'b1;
				res.status         = (diff != '0) ? ST_SUM_ERR : ST_OK;
				res.sum_difference = diff;
				res.block_number   = blk_q;
			end else if (pos_q == end_pos) begin
				pos_d = pos_q + POS_ONE;
			end else begin
				skip_d           = 1'b1;
				hit              = 1'b1;
				res.frame_done   = 1'b1;
				res.status       = ST_OK;
				res.block_number = blk_q;
				res.long_frame   = 1'b1;
			end
		end
	end

	assign res_valid = adv_s1 && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			sum_q  <= '0;
			long_q <= 1'b0;
			skip_q <= 1'b1;
			blk_q  <= '0;
		end else if (adv_s1) begin
			pos_q  <= pos_d;
			sum_q  <= sum_d;
			long_q <= long_d;
			skip_q <= skip_d;
			blk_q  <= blk_d;
		end
	end

endmodule

[rtl/core/xfc_out_buf.sv]
// Two-entry output register with skid slot for XMODEM frame checker results.
// Depends on xfc_pkg.
module xfc_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  xfc_pkg::res_t push_data,
	output logic          room,
	output logic          out_valid,
	input  logic          out_ready,
	output xfc_pkg::res_t out_data
);
	import xfc_pkg::*;

	logic main_v_q, skid_v_q;
	res_t main_q, skid_q;
	logic pop;

	assign pop       = main_v_q && out_ready;
	assign room      = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (!main_v_q || pop) begin
				main_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (!main_v_q || pop) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for xmodem_frame_checker_core: random and directed XMODEM frames
// go in on the byte stream, and every result is checked against a local frame tracker.
// Depends on xfc_pkg and the core RTL.
module tb_top;
	import xfc_pkg::*;

	localparam int SHORT_LEN = SHORT_PAYLOAD_DEF;
	localparam int LONG_LEN  = LONG_PAYLOAD_DEF;

	typedef struct packed {
		logic [7:0] b;
		logic       first;
	} rx_item_t;

	typedef enum {FR_GOOD, FR_LONG_FULL, FR_CUT, FR_BAD_COMPL, FR_BAD_START, FR_NOISE} frame_kind_t;

	// {first flag, byte}
	localparam logic [8:0] DIRECTED [22] = '{
		9'h100, 9'h1ff, 9'h033,
		9'h101, 9'h000, 9'h0ff, 9'h0ff, 9'h080,
		9'h102, 9'h0ff, 9'h000, 9'h0a5,
		9'h101, 9'h005, 9'h005, 9'h012,
		9'h102, 9'h080, 9'h080,
		9'h101, 9'h0ff, 9'h0ff
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SHORT_START;
	logic [7:0]  cfg_data = 8'h00;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;  // rx_byte
	logic        s_tuser = 1'b0;   // frame_first
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;          // payload_byte, payload_index, status, sum_difference,
	                               // block_number, long_frame, zero pad
	logic        m_tuser;          // is_payload
	logic        m_tlast;          // frame_done

	rx_item_t    rx_pending[$];
	res_t        due_results[$];
	int          items_queued = 0;
	int          items_taken = 0;
	int          rand_items = 0;
	int          mismatches = 0;

	// tracker copy of the block's registers and frame state
	logic [7:0]  short_code = SHORT_START_RST;
	logic [7:0]  long_code = LONG_START_RST;
	int          pos = 0;
	logic [7:0]  run_sum = 8'h00;
	logic        kind_long = 1'b0;
	logic        skipping = 1'b1;
	logic [7:0]  held_blk = 8'h00;

	logic        in_took = 1'b0;
	logic        out_took = 1'b0;
	int          in_gap = 0;
	int          out_stall = 0;
	bit          in_calm = 1'b0;
	bit          out_calm = 1'b0;
	rx_item_t    nxt;
	res_t        got;
	res_t        want;

	xmodem_frame_checker_core #(
		.SHORT_PAYLOAD(SHORT_LEN),
		.LONG_PAYLOAD (LONG_LEN)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	task automatic frame_track(input logic [7:0] b, input logic first);
		res_t r;
		int plen;
		logic [7:0] diff;
		r = '0;
		plen = kind_long ? LONG_LEN : SHORT_LEN;
		if (first) begin
			run_sum = 8'h00;
			held_blk = 8'h00;
			if (b == short_code || b == long_code) begin
				kind_long = (b != short_code);
				pos = 1;
				skipping = 1'b0;
			end else begin
				kind_long = 1'b0;
				pos = 0;
				skipping = 1'b1;
				r.frame_done = 1'b1;
				r.status = ST_BAD_START;
				due_results.push_back(r);
			end
		end else if (skipping) begin
		end else if (pos == 1) begin
			held_blk = b;
			pos = 2;
		end else if (pos == 2) begin
			if (int'(held_blk) + int'(b) != 255) begin
				skipping = 1'b1;
				r.frame_done = 1'b1;
				r.status = ST_BAD_COMPL;
				r.block_number = held_blk;
				r.long_frame = kind_long;
				due_results.push_back(r);
			end else
				pos = 3;
		end else if (pos < 3 + plen) begin
			r.is_payload = 1'b1;
			r.payload_byte = b;
			r.payload_index = INDEX_W'(pos - 3);
			r.block_number = held_blk;
			r.long_frame = kind_long;
			run_sum = run_sum + b;
			pos++;
			due_results.push_back(r);
		end else if (!kind_long) begin
			diff = run_sum - b;
			skipping = 1'b1;
			r.frame_done = 1'b1;
			r.status = (diff != 8'h00) ? ST_SUM_ERR : ST_OK;
			r.sum_difference = diff;
			r.block_number = held_blk;
			due_results.push_back(r);
		end else if (pos == 3 + plen) begin
			pos++;
		end else begin
			skipping = 1'b1;
			r.frame_done = 1'b1;
			r.status = ST_OK;
			r.block_number = held_blk;
			r.long_frame = 1'b1;
			due_results.push_back(r);
		end
	endtask

	task automatic check_field(input string fname, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, fname, exp_v, act_v);
			mismatches++;
		end
	endtask

	task automatic push_item(input logic [7:0] b, input logic first, input bit counted);
		rx_pending.push_back('{b, first});
		items_queued++;
		if (counted)
			rand_items++;
	endtask

	task automatic push_frame(input frame_kind_t k);
		logic [7:0] blk;
		logic [7:0] sum;
		logic [7:0] b;
		logic [7:0] start;
		int n;
		int cut;
		blk = 8'($urandom_range(0, 255));
		sum = 8'h00;
		cut = $urandom_range(0, 4);
		start = $urandom_range(0, 1) ? long_code : short_code;
		if (k == FR_GOOD)
			start = short_code;
		if (k == FR_LONG_FULL)
			start = long_code;
		case (k)
			FR_BAD_START: begin
				do
					b = 8'($urandom_range(0, 255));
				while (b == short_code || b == long_code);
				push_item(b, 1'b1, 1'b1);
			end
			FR_NOISE: begin
				repeat ($urandom_range(1, 6))
					push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			default: begin
				push_item(start, 1'b1, 1'b1);
				if (!(k == FR_CUT && cut == 0))
					push_item(blk, 1'b0, 1'b1);
				if (k == FR_BAD_COMPL) begin
					do
						b = 8'($urandom_range(0, 255));
					while (int'(blk) + int'(b) == 255);
					push_item(b, 1'b0, 1'b1);
				end else if (!(k == FR_CUT && cut < 2)) begin
					push_item(~blk, 1'b0, 1'b1);
					n = (k == FR_LONG_FULL) ? LONG_LEN :
						(k == FR_GOOD) ? SHORT_LEN : $urandom_range(0, 12);
					repeat (n) begin
						b = 8'($urandom_range(0, 255));
						sum = sum + b;
						push_item(b, 1'b0, 1'b1);
					end
					if (k == FR_LONG_FULL) begin
						push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
						push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
					end else if (k == FR_GOOD) begin
						b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : sum;
						push_item(b, 1'b0, 1'b1);
					end
				end
			end
		endcase
	endtask

	task automatic fill_random(input int target);
		int base;
		int r;
		base = rand_items;
		while (rand_items - base < target) begin
			r = $urandom_range(0, 99);
			if (r < 12 && target - (rand_items - base) >= SHORT_LEN + 3)
				push_frame(FR_GOOD);
			else if (r < 45)
				push_frame(FR_CUT);
			else if (r < 62)
				push_frame(FR_BAD_COMPL);
			else if (r < 78)
				push_frame(FR_BAD_START);
			else
				push_frame(FR_NOISE);
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (items_taken != items_queued || due_results.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == CFG_SHORT_START)
			short_code = val;
		else
			long_code = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// item source
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !in_took)) begin
			if (in_gap > 0) begin
				in_gap--;
				s_tvalid <= 1'b0;
			end else if (rx_pending.size() > 0) begin
				nxt = rx_pending.pop_front();
				s_tdata <= nxt.b;
				s_tuser <= nxt.first;
				s_tvalid <= 1'b1;
				if ($urandom_range(0, 39) == 0)
					in_calm = !in_calm;
				in_gap = draw_wait(in_calm);
			end else
				s_tvalid <= 1'b0;
		end
	end

	// result sink backpressure
	always @(negedge clk) begin
		if (out_took) begin
			if ($urandom_range(0, 39) == 0)
				out_calm = !out_calm;
			out_stall = draw_wait(out_calm);
		end
		if (out_stall > 0) begin
			out_stall--;
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		in_took <= s_tvalid && s_tready;
		out_took <= m_tvalid && m_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				frame_track(s_tdata, s_tuser);
				items_taken++;
			end
			if (m_tvalid && m_tready) begin
				got.is_payload = m_tuser;
				got.payload_byte = m_tdata[7:0];
				got.payload_index = m_tdata[17:8];
				got.frame_done = m_tlast;
				got.status = status_t'(m_tdata[19:18]);
				got.sum_difference = m_tdata[27:20];
				got.block_number = m_tdata[35:28];
				got.long_frame = m_tdata[36];
				if (due_results.size() == 0) begin
					$display("%0t: result expected none actual %h", $time, got);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("is_payload", want.is_payload, got.is_payload);
					check_field("payload_byte", want.payload_byte, got.payload_byte);
					check_field("payload_index", want.payload_index, got.payload_index);
					check_field("frame_done", want.frame_done, got.frame_done);
					check_field("status", want.status, got.status);
					check_field("sum_difference", want.sum_difference, got.sum_difference);
					check_field("block_number", want.block_number, got.block_number);
					check_field("long_frame", want.long_frame, got.long_frame);
				end
			end
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			push_item(DIRECTED[i][7:0], DIRECTED[i][8], 1'b0);
		fill_random(60);
		wait_drained();

		cfg_write(CFG_SHORT_START, 8'h00);
		cfg_write(CFG_LONG_START, 8'hff);
		fill_random(60);
		wait_drained();

		// equal codes: a match on both starts a short frame
		cfg_write(CFG_SHORT_START, 8'h55);
		cfg_write(CFG_LONG_START, 8'h55);
		fill_random(60);
		wait_drained();

		cfg_write(CFG_SHORT_START, 8'hff);
		cfg_write(CFG_LONG_START, 8'h00);
		push_frame(FR_GOOD);
		fill_random(60);
		wait_drained();

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
